/* rtl/core/cxacc_pkg.sv */
// shared types, constants and helpers for the complex accumulator alu
package cxacc_pkg;

  localparam int unsigned MaxExpDefault = 255;
  localparam int unsigned TolWidth      = 31;

  typedef enum logic [3:0] {
    FUNC_LOAD  = 4'd0,
    FUNC_ADD   = 4'd1,
    FUNC_SUB   = 4'd2,
    FUNC_MUL   = 4'd3,
    FUNC_DIV   = 4'd4,
    FUNC_NEG   = 4'd5,
    FUNC_EQUAL = 4'd6,
    FUNC_MAG   = 4'd7,
    FUNC_POWER = 4'd8
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMUL,
    ST_CMUL_FIN,
    ST_PWR_STEP,
    ST_DIV_PROD,
    ST_DIV_RE,
    ST_DIV_IM,
    ST_MAG_PROD,
    ST_SQRT,
    ST_DONE
  } state_e;

  // one signed 33x33 product request to the shared multiplier
  typedef struct packed {
    logic signed [32:0] a;
    logic signed [32:0] b;
  } mul_req_t;

  // saturate a 66-bit signed value to 32 bits
  function automatic logic [32:0] sat_s32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sd2147483647)       r = {1'b1, 32'h7fffffff};
    else if (v < -66'sd2147483648) r = {1'b1, 32'h80000000};
    else                           r = {1'b0, v[31:0]};
    return r;
  endfunction

  // round a Q32.32 sum (ties away from zero) and saturate
  function automatic logic [32:0] round_q(input logic signed [65:0] v);
    logic [65:0] m;
    logic [65:0] r;
    logic signed [65:0] s;
    m = v[65] ? 66'(-v) : v;
    r = (m + 66'd32768) >> 16;
    s = v[65] ? 66'(-$signed(r)) : $signed(r);
    return sat_s32(s);
  endfunction

endpackage

/* rtl/core/cxacc_mul.sv */
// shared signed 33x33 multiplier with a registered product
module cxacc_mul (
  input  logic                     clk_i,
  input  cxacc_pkg::mul_req_t      req_i,
  output logic signed [65:0]       prod_o
);
  import cxacc_pkg::*;

  logic signed [65:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= req_i.a * req_i.b;
  end

  assign prod_o = prod_q;
endmodule

/* rtl/core/cxacc_div.sv */
// restoring divider, one quotient bit per cycle
module cxacc_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  num_i,
  input  logic [63:0]  den_i,
  output logic         done_o,
  output logic [47:0]  quot_o
);
  import cxacc_pkg::*;

  // quotient of num*2^16/den needs 80 numerator bits
  logic [79:0] rem_q, rem_d;
  logic [79:0] quo_q, quo_d;
  logic [63:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [80:0] shifted;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    shifted = '0;
    if (start_i) begin
      rem_d = '0;
      quo_d = {num_i, 16'h0};
      den_d = den_i;
      cnt_d = 7'd80;
      run_d = 1'b1;
    end else if (run_q) begin
      shifted = {rem_q, quo_q[79]};
      quo_d   = {quo_q[78:0], 1'b0};
      if (shifted >= {17'h0, den_q}) begin
        rem_d    = 80'(shifted - {17'h0, den_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = shifted[79:0];
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  // quotient at or above 2^48 saturates in any case
  assign quot_o = (quo_q[79:48] != '0) ? 48'hffffffffffff : quo_q[47:0];
endmodule

/* rtl/core/complex_accumulator_alu_core.sv */
// top level of the complex accumulator alu
//
// Usage: hold func_i, operand_real_i, operand_imag_i and exponent_i with start_i
// high; the item transfers at a rising edge where busy_o is low and busy_o rises.
// done_o is high for exactly one cycle with result_real_o, result_imag_o,
// mag_out_o, flag_o and overflow_o; the receiver cannot stall the block and the
// results are held only until the next item transfers.
// Flow from the transfer edge: load, add, sub, negate, equal, magnitude and unused
// codes go straight to the magnitude; multiply does its products first, divide its
// products and then two divider runs (none for a zero divisor), and power a
// square-and-multiply over the bits of the clamped exponent. A complex multiply is
// four products on the one shared multiplier, each quotient of a divide takes 80
// one-bit steps, and every item ends with two squares and a restoring square root
// for the magnitude. busy_o falls in the cycle after done_o, so a new item is taken
// only after the last one is done. tol_we_i writes the 31-bit tolerance; the user
// must write it only while busy_o is low, and the block does not enforce this.
// Reset clears the accumulator to zero and the tolerance to one.
module complex_accumulator_alu_core #(
  parameter int unsigned MAX_EXP = cxacc_pkg::MaxExpDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [3:0]                     func_i,
  input  logic signed [31:0]             operand_real_i,
  input  logic signed [31:0]             operand_imag_i,
  input  logic [7:0]                     exponent_i,
  input  logic                           tol_we_i,
  input  logic [cxacc_pkg::TolWidth-1:0] tol_wdata_i,
  output logic                           done_o,
  output logic signed [31:0]             result_real_o,
  output logic signed [31:0]             result_imag_o,
  output logic [31:0]                    mag_out_o,
  output logic                           flag_o,
  output logic                           overflow_o
);
  import cxacc_pkg::*;

  state_e state_q, state_d;
  logic signed [31:0] acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic [3:0]  func_q;
  logic [7:0]  exp_q;
  logic [TolWidth-1:0] tol_q;
  logic signed [31:0] wr_q, wr_d, wi_q, wi_d;   // left factor (power result / acc)
  logic signed [31:0] br_q, br_d, bi_q, bi_d;   // right factor / operand
  logic signed [65:0] pre_q, pre_d, pim_q, pim_d;
  logic [2:0]  idx_q, idx_d;
  logic [3:0]  pbit_q, pbit_d;                  // power: current bit plus one
  logic        sqr_q, sqr_d;                    // power: squaring comes next
  logic        ovf_q, ovf_d, flag_q, flag_d;
  logic [63:0] den_q, den_d;
  logic signed [65:0] num_re_q, num_re_d, num_im_q, num_im_d;
  logic [63:0] sq_q, sq_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;

  mul_req_t           mreq;
  logic signed [65:0] prod;
  logic               div_start, div_done;
  logic [63:0]        div_num;
  logic [47:0]        div_quot;
  logic [32:0]        s1, s2;
  logic signed [32:0] d_re, d_im;
  logic [32:0]        m_re, m_im;
  logic signed [65:0] qs;
  logic [35:0]        trial;
  logic [7:0]         n_eff;
  logic [2:0]         pidx;

  cxacc_mul u_mul (.clk_i(clk_i), .req_i(mreq), .prod_o(prod));

  cxacc_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .num_i(div_num), .den_i(den_q), .done_o(div_done), .quot_o(div_quot)
  );

  assign n_eff = (32'(exponent_i) > MAX_EXP) ? 8'(MAX_EXP) : exponent_i;
  assign pidx  = 3'(pbit_q - 4'd1);

  // multiplier operand selection, the product is registered and arrives in the next cycle
  always_comb begin
    mreq = '0;
    unique case (state_q)
      ST_CMUL: begin
        unique case (idx_q)
          3'd0:    mreq = '{a: 33'(wr_q), b: 33'(br_q)};
          3'd1:    mreq = '{a: 33'(wi_q), b: 33'(bi_q)};
          3'd2:    mreq = '{a: 33'(wr_q), b: 33'(bi_q)};
          3'd3:    mreq = '{a: 33'(wi_q), b: 33'(br_q)};
          default: mreq = '0;
        endcase
      end
      ST_DIV_PROD: begin
        unique case (idx_q)
          3'd0:    mreq = '{a: 33'(br_q), b: 33'(br_q)};
          3'd1:    mreq = '{a: 33'(bi_q), b: 33'(bi_q)};
          3'd2:    mreq = '{a: 33'(wr_q), b: 33'(br_q)};
          3'd3:    mreq = '{a: 33'(wi_q), b: 33'(bi_q)};
          3'd4:    mreq = '{a: 33'(wi_q), b: 33'(br_q)};
          3'd5:    mreq = '{a: 33'(wr_q), b: 33'(bi_q)};
          default: mreq = '0;
        endcase
      end
      ST_MAG_PROD: begin
        unique case (idx_q)
          3'd0:    mreq = '{a: 33'(acc_re_q), b: 33'(acc_re_q)};
          3'd1:    mreq = '{a: 33'(acc_im_q), b: 33'(acc_im_q)};
          default: mreq = '0;
        endcase
      end
      default: mreq = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) begin
        unique case (func_i)
          FUNC_MUL:   state_d = ST_CMUL;
          FUNC_POWER: state_d = ST_PWR_STEP;
          FUNC_DIV:   state_d = ST_DIV_PROD;
          default:    state_d = ST_MAG_PROD;
        endcase
      end
      ST_CMUL:      if (idx_q == 3'd4) state_d = ST_CMUL_FIN;
      ST_CMUL_FIN:  state_d = (func_q == FUNC_POWER) ? ST_PWR_STEP : ST_MAG_PROD;
      ST_PWR_STEP: begin
        if (sqr_q) state_d = (pbit_q == 4'd0) ? ST_MAG_PROD : ST_CMUL;
        else if (exp_q[pidx]) state_d = ST_CMUL;
      end
      ST_DIV_PROD:  if (idx_q == 3'd6) state_d = (den_q == '0) ? ST_MAG_PROD : ST_DIV_RE;
      ST_DIV_RE:    if (div_done) state_d = ST_DIV_IM;
      ST_DIV_IM:    if (div_done) state_d = ST_MAG_PROD;
      ST_MAG_PROD:  if (idx_q == 3'd2) state_d = ST_SQRT;
      ST_SQRT:      if (cnt_q == 5'd0) state_d = ST_DONE;
      ST_DONE:      state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    acc_re_d = acc_re_q; acc_im_d = acc_im_q;
    wr_d = wr_q; wi_d = wi_q; br_d = br_q; bi_d = bi_q;
    pre_d = pre_q; pim_d = pim_q; pbit_d = pbit_q; sqr_d = sqr_q;
    ovf_d = ovf_q; flag_d = flag_q; den_d = den_q;
    num_re_d = num_re_q; num_im_d = num_im_q;
    sq_d = sq_q; rem_d = rem_q; root_d = root_q; cnt_d = cnt_q;
    div_start = 1'b0;
    div_num = '0;
    s1 = '0; s2 = '0; d_re = '0; d_im = '0; m_re = '0; m_im = '0;
    qs = '0; trial = '0;
    unique case (state_q)
      ST_IDLE: if (start_i) begin
        ovf_d = 1'b0; flag_d = 1'b0;
        wr_d = acc_re_q; wi_d = acc_im_q;
        br_d = operand_real_i; bi_d = operand_imag_i;
        unique case (func_i)
          FUNC_LOAD: begin
            acc_re_d = operand_real_i; acc_im_d = operand_imag_i;
          end
          FUNC_ADD: begin
            s1 = sat_s32(66'(acc_re_q) + 66'(operand_real_i));
            s2 = sat_s32(66'(acc_im_q) + 66'(operand_imag_i));
            acc_re_d = s1[31:0]; acc_im_d = s2[31:0]; ovf_d = s1[32] | s2[32];
          end
          FUNC_SUB: begin
            s1 = sat_s32(66'(acc_re_q) - 66'(operand_real_i));
            s2 = sat_s32(66'(acc_im_q) - 66'(operand_imag_i));
            acc_re_d = s1[31:0]; acc_im_d = s2[31:0]; ovf_d = s1[32] | s2[32];
          end
          FUNC_NEG: begin
            s1 = sat_s32(-66'(acc_re_q));
            s2 = sat_s32(-66'(acc_im_q));
            acc_re_d = s1[31:0]; acc_im_d = s2[31:0]; ovf_d = s1[32] | s2[32];
          end
          FUNC_EQUAL: begin
            d_re = 33'(operand_real_i) - 33'(acc_re_q);
            d_im = 33'(operand_imag_i) - 33'(acc_im_q);
            m_re = d_re[32] ? 33'(-d_re) : 33'(d_re);
            m_im = d_im[32] ? 33'(-d_im) : 33'(d_im);
            flag_d = (m_re < {2'b00, tol_q}) && (m_im < {2'b00, tol_q});
          end
          FUNC_POWER: begin
            // result starts at one, square-and-multiply over the 8 exponent bits
            wr_d = 32'sd65536; wi_d = '0;
            pbit_d = 4'd8; sqr_d = 1'b1;
          end
          default: ;
        endcase
      end
      ST_CMUL: begin
        unique case (idx_q)
          3'd1:    pre_d = prod;
          3'd2:    pre_d = pre_q - prod;
          3'd3:    pim_d = prod;
          3'd4:    pim_d = pim_q + prod;
          default: ;
        endcase
      end
      ST_CMUL_FIN: begin
        s1 = round_q(pre_q);
        s2 = round_q(pim_q);
        ovf_d = ovf_q | s1[32] | s2[32];
        if (func_q == FUNC_POWER) begin
          wr_d = s1[31:0]; wi_d = s2[31:0];
        end else begin
          acc_re_d = s1[31:0]; acc_im_d = s2[31:0];
        end
      end
      ST_PWR_STEP: begin
        if (sqr_q) begin
          if (pbit_q == 4'd0) begin
            acc_re_d = wr_q; acc_im_d = wi_q;
          end else begin
            br_d = wr_q; bi_d = wi_q; sqr_d = 1'b0;
          end
        end else begin
          sqr_d = 1'b1; pbit_d = pbit_q - 4'd1;
          if (exp_q[pidx]) begin
            br_d = acc_re_q; bi_d = acc_im_q;
          end
        end
      end
      ST_DIV_PROD: begin
        unique case (idx_q)
          3'd1: pre_d = prod;
          3'd2: den_d = 64'(pre_q + prod);
          3'd3: pre_d = prod;
          3'd4: num_re_d = pre_q + prod;
          3'd5: pre_d = prod;
          3'd6: begin
            num_im_d = pre_q - prod;
            if (den_q != '0) begin
              div_start = 1'b1;
              div_num = 64'(num_re_q[65] ? -num_re_q : num_re_q);
              flag_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_DIV_RE: if (div_done) begin
        qs = num_re_q[65] ? -$signed({18'h0, div_quot}) : $signed({18'h0, div_quot});
        s1 = sat_s32(qs);
        acc_re_d = s1[31:0]; ovf_d = ovf_q | s1[32];
        div_start = 1'b1;
        div_num = 64'(num_im_q[65] ? -num_im_q : num_im_q);
      end
      ST_DIV_IM: if (div_done) begin
        qs = num_im_q[65] ? -$signed({18'h0, div_quot}) : $signed({18'h0, div_quot});
        s2 = sat_s32(qs);
        acc_im_d = s2[31:0]; ovf_d = ovf_q | s2[32];
      end
      ST_MAG_PROD: begin
        unique case (idx_q)
          3'd1: pre_d = prod;
          3'd2: begin
            sq_d = 64'(pre_q + prod);
            rem_d = '0; root_d = '0; cnt_d = 5'd31;
          end
          default: ;
        endcase
      end
      ST_SQRT: begin
        // restoring square root, two radicand bits a cycle
        trial = {rem_q, sq_q[63:62]} - {2'b00, root_q, 2'b01};
        if (!trial[35]) begin
          rem_d = trial[33:0];
          root_d = {root_q[30:0], 1'b1};
        end else begin
          rem_d = {rem_q[31:0], sq_q[63:62]};
          root_d = {root_q[30:0], 1'b0};
        end
        sq_d = {sq_q[61:0], 2'b00};
        cnt_d = cnt_q - 5'd1;
      end
      ST_DONE: ;
      default: ;
    endcase
    // product index restarts on every state change
    if (state_d != state_q) idx_d = '0;
    else                    idx_d = idx_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_re_q <= '0;
      acc_im_q <= '0;
      tol_q <= TolWidth'(1);
      idx_q <= '0;
      pbit_q <= '0;
      sqr_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
      idx_q <= idx_d;
      pbit_q <= pbit_d;
      sqr_q <= sqr_d;
      cnt_q <= cnt_d;
      if (tol_we_i) tol_q <= tol_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      func_q <= func_i; exp_q <= n_eff;
    end
    wr_q <= wr_d; wi_q <= wi_d; br_q <= br_d; bi_q <= bi_d;
    pre_q <= pre_d; pim_q <= pim_d;
    ovf_q <= ovf_d; flag_q <= flag_d; den_q <= den_d;
    num_re_q <= num_re_d; num_im_q <= num_im_d;
    sq_q <= sq_d; rem_q <= rem_d; root_q <= root_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = (state_q == ST_DONE);
  assign result_real_o = acc_re_q;
  assign result_imag_o = acc_im_q;
  assign mag_out_o     = root_q;
  assign flag_o        = flag_q;
  assign overflow_o    = ovf_q;

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o) else $error("done without idle");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("transfer not taken");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");
  a_idle_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !done_o) else $error("done while idle");
`endif
endmodule

/* tb/tb_top.sv */
// self-checking testbench for the complex accumulator alu core
`timescale 1ns / 1ps

module tb_top;
  import cxacc_pkg::*;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [31:0]        mag;
    bit                 flag;
    bit                 ovf;
  } cx_result_t;

  typedef struct {
    logic [3:0]         f;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [7:0]         e;
    bit                 lit;
    cx_result_t         want;
  } stim_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic                    busy_o;
  logic [3:0]              func_i = '0;
  logic signed [31:0]      operand_real_i = '0;
  logic signed [31:0]      operand_imag_i = '0;
  logic [7:0]              exponent_i = '0;
  logic                    tol_we_i = 1'b0;
  logic [TolWidth-1:0]     tol_wdata_i = '0;
  logic                    done_o;
  logic signed [31:0]      result_real_o;
  logic signed [31:0]      result_imag_o;
  logic [31:0]             mag_out_o;
  logic                    flag_o;
  logic                    overflow_o;

  // predictor state
  longint      acc_re, acc_im;
  logic [63:0] tol_q;
  cx_result_t  pending_q[$];
  int          fail_cnt = 0;
  stim_row_t   dir_rows[$];

  always #5 clk_i = ~clk_i;

  complex_accumulator_alu_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .func_i        (func_i),
    .operand_real_i(operand_real_i),
    .operand_imag_i(operand_imag_i),
    .exponent_i    (exponent_i),
    .tol_we_i      (tol_we_i),
    .tol_wdata_i   (tol_wdata_i),
    .done_o        (done_o),
    .result_real_o (result_real_o),
    .result_imag_o (result_imag_o),
    .mag_out_o     (mag_out_o),
    .flag_o        (flag_o),
    .overflow_o    (overflow_o)
  );

  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint clamp32(longint v, inout bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // sign-magnitude a*b +/- c*d
  function automatic logic [63:0] prod_sum(longint a, longint b, longint c, longint d,
                                           bit sub, output bit neg);
    logic [63:0] m1, m2;
    bit n1, n2;
    m1 = mag64(a) * mag64(b);
    m2 = mag64(c) * mag64(d);
    n1 = (a < 0) != (b < 0);
    n2 = ((c < 0) != (d < 0)) != sub;
    if (m1 == 0) n1 = 1'b0;
    if (m2 == 0) n2 = n1;
    if (n1 == n2) begin
      neg = n1;
      return m1 + m2;
    end
    if (m1 >= m2) begin
      neg = n1;
      return m1 - m2;
    end
    neg = n2;
    return m2 - m1;
  endfunction

  function automatic longint pack_s32(bit neg, logic [63:0] m, inout bit ovf);
    if (!neg) begin
      if (m > 64'h7fff_ffff) begin
        ovf = 1'b1;
        return 64'sd2147483647;
      end
      return longint'(m);
    end
    if (m > 64'h8000_0000) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return -longint'(m);
  endfunction

  task automatic cx_mul(inout longint ar, inout longint ai, input longint br,
                        input longint bi, inout bit ovf);
    bit nr, ni;
    logic [63:0] mr, mi;
    mr = prod_sum(ar, br, ai, bi, 1'b1, nr);
    mi = prod_sum(ar, bi, ai, br, 1'b0, ni);
    ar = pack_s32(nr, (mr + 64'd32768) >> 16, ovf);
    ai = pack_s32(ni, (mi + 64'd32768) >> 16, ovf);
  endtask

  function automatic logic [63:0] frac_div(logic [63:0] num, logic [63:0] den);
    logic [63:0] qi, r, q;
    qi = num / den;
    r  = num % den;
    if (qi >= 64'd65536) return 64'hFFFF_FFFF_FFFF;
    q = qi << 16;
    for (int k = 15; k >= 0; k--) begin
      if (r >= den - r) begin
        r = r - (den - r);
        q[k] = 1'b1;
      end else begin
        r = r << 1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic predict_alu(input logic [3:0] f, input logic signed [31:0] op_re,
                             input logic signed [31:0] op_im, input logic [7:0] e,
                             output cx_result_t r);
    longint br, bi, rr, ri, zr, zi, sr, si;
    logic [63:0] den, mr, mi, m;
    int unsigned n;
    bit nr, ni, flag, ovf;
    br = op_re;
    bi = op_im;
    flag = 1'b0;
    ovf = 1'b0;
    case (f)
      FUNC_LOAD: begin
        acc_re = br;
        acc_im = bi;
      end
      FUNC_ADD: begin
        acc_re = clamp32(acc_re + br, ovf);
        acc_im = clamp32(acc_im + bi, ovf);
      end
      FUNC_SUB: begin
        acc_re = clamp32(acc_re - br, ovf);
        acc_im = clamp32(acc_im - bi, ovf);
      end
      FUNC_MUL: cx_mul(acc_re, acc_im, br, bi, ovf);
      FUNC_DIV: begin
        den = mag64(br) * mag64(br) + mag64(bi) * mag64(bi);
        if (den != 0) begin
          mr = prod_sum(acc_re, br, acc_im, bi, 1'b0, nr);
          mi = prod_sum(acc_im, br, acc_re, bi, 1'b1, ni);
          acc_re = pack_s32(nr, frac_div(mr, den), ovf);
          acc_im = pack_s32(ni, frac_div(mi, den), ovf);
          flag = 1'b1;
        end
      end
      FUNC_NEG: begin
        acc_re = clamp32(-acc_re, ovf);
        acc_im = clamp32(-acc_im, ovf);
      end
      FUNC_EQUAL: flag = (mag64(br - acc_re) < tol_q) && (mag64(bi - acc_im) < tol_q);
      FUNC_POWER: begin
        rr = 65536;
        ri = 0;
        zr = acc_re;
        zi = acc_im;
        n = (e > MaxExpDefault) ? MaxExpDefault : e;
        for (int k = 15; k >= 0; k--) begin
          sr = rr;
          si = ri;
          cx_mul(rr, ri, sr, si, ovf);
          if ((n >> k) & 1) cx_mul(rr, ri, zr, zi, ovf);
        end
        acc_re = rr;
        acc_im = ri;
      end
      default: ;
    endcase
    m = int_sqrt(mag64(acc_re) * mag64(acc_re) + mag64(acc_im) * mag64(acc_im));
    if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
    r.re   = acc_re[31:0];
    r.im   = acc_im[31:0];
    r.mag  = m[31:0];
    r.flag = flag;
    r.ovf  = ovf;
  endtask

  // one transfer, with random sender gaps in front of it
  task automatic send_item(input logic [3:0] f, input logic signed [31:0] op_re,
                           input logic signed [31:0] op_im, input logic [7:0] e,
                           input bit lit, input cx_result_t want, input int idle_pct);
    cx_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    func_i = f;
    operand_real_i = op_re;
    operand_imag_i = op_im;
    exponent_i = e;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
    predict_alu(f, op_re, op_im, e, r);
    pending_q.push_back(lit ? want : r);
    @(negedge clk_i);
  endtask

  task automatic write_tol(input logic [TolWidth-1:0] v);
    start_i = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    tol_we_i = 1'b1;
    tol_wdata_i = v;
    @(negedge clk_i);
    tol_we_i = 1'b0;
    tol_q = 64'(v);
  endtask

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $signed($urandom_range(0, 2 ** 19)) - 32'sd262144;
      5, 6, 7:       return $urandom;
      8: case ($urandom_range(4))
           0: return 32'sh7fff_ffff;
           1: return 32'sh8000_0000;
           2: return 32'shffff_ffff;
           3: return 32'sd1;
           default: return 32'sd65536;
         endcase
      default: return 32'sd0;
    endcase
  endfunction

  function automatic stim_row_t mk_row(logic [3:0] f, logic signed [31:0] re,
                                       logic signed [31:0] im, logic [7:0] e, bit lit,
                                       logic signed [31:0] w_re, logic signed [31:0] w_im,
                                       logic [31:0] w_mag, bit w_flag, bit w_ovf);
    stim_row_t s;
    s.f = f; s.re = re; s.im = im; s.e = e; s.lit = lit;
    s.want = '{w_re, w_im, w_mag, w_flag, w_ovf};
    return s;
  endfunction

  always @(posedge clk_i) begin
    cx_result_t x;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing pending");
        fail_cnt++;
      end else begin
        x = pending_q.pop_front();
        if (result_real_o !== x.re) begin
          $error("result_real exp %h got %h", x.re, result_real_o);
          fail_cnt++;
        end
        if (result_imag_o !== x.im) begin
          $error("result_imag exp %h got %h", x.im, result_imag_o);
          fail_cnt++;
        end
        if (mag_out_o !== x.mag) begin
          $error("mag_out exp %h got %h", x.mag, mag_out_o);
          fail_cnt++;
        end
        if (flag_o !== x.flag) begin
          $error("flag exp %b got %b", x.flag, flag_o);
          fail_cnt++;
        end
        if (overflow_o !== x.ovf) begin
          $error("overflow exp %b got %b", x.ovf, overflow_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [3:0] f;
    logic signed [31:0] op_re, op_im;
    logic [7:0] e;
    int idle_pct, rnd;
    logic [TolWidth-1:0] tol_set[6];
    acc_re = 0;
    acc_im = 0;
    tol_q = 64'd1;
    // extremes, near-match band and random settings
    tol_set = '{31'd0, 31'h7fff_ffff, 31'd65536, TolWidth'($urandom), 31'd1,
                TolWidth'($urandom_range(0, 1000))};

    dir_rows.push_back(mk_row(FUNC_MAG, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_LOAD, 65536, 0, 0, 1, 65536, 0, 65536, 0, 0));
    // divide by zero keeps the accumulator
    dir_rows.push_back(mk_row(FUNC_DIV, 0, 0, 0, 1, 65536, 0, 65536, 0, 0));
    // zero exponent gives one
    dir_rows.push_back(mk_row(FUNC_POWER, 0, 0, 0, 1, 65536, 0, 65536, 0, 0));
    dir_rows.push_back(mk_row(FUNC_LOAD, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0,
                              0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_ADD, 1, 1, 8'hff, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_MUL, 131072, 131072, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_LOAD, 32'sh8000_0000, 0, 0, 1,
                              32'sh8000_0000, 0, 32'h8000_0000, 0, 0));
    dir_rows.push_back(mk_row(FUNC_NEG, 0, 0, 0, 1,
                              32'sh7fff_ffff, 0, 32'h7fff_ffff, 0, 1));
    dir_rows.push_back(mk_row(FUNC_SUB, 32'sh8000_0000, 32'sh8000_0000, 0, 0,
                              0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_LOAD, 196608, 262144, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_DIV, 65536, 65536, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_MUL, 32'shffff_ffff, 1, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_LOAD, 229376, -32'sd32768, 0, 0, 0, 0, 0, 0, 0));
    // exact match inside the default tolerance, then a miss
    dir_rows.push_back(mk_row(FUNC_EQUAL, 229376, -32'sd32768, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_EQUAL, 229377, -32'sd32768, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_LOAD, 32768, 32768, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_POWER, 0, 0, 3, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_DIV, 32'sh8000_0000, 32'sh8000_0000, 0, 0,
                              0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(4'hf, 32'shffff_ffff, 32'shffff_ffff, 8'hff, 0,
                              0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_LOAD, 131072, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_POWER, 0, 0, 255, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_LOAD, 65536, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_POWER, 0, 0, 255, 0, 0, 0, 0, 0, 0));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].f, dir_rows[i].re, dir_rows[i].im, dir_rows[i].e,
                dir_rows[i].lit, dir_rows[i].want, 0);

    for (int ph = 0; ph < 6; ph++) begin
      write_tol(tol_set[ph]);
      idle_pct = (ph < 2) ? 13 : (ph < 4) ? 67 : 0;
      for (int k = 0; k < 275; k++) begin
        rnd = $urandom_range(99);
        if (rnd < 6)       f = 4'($urandom_range(9, 15));
        else if (rnd < 22) f = FUNC_LOAD;
        else               f = 4'($urandom_range(0, 8));
        op_re = rand_q();
        op_im = rand_q();
        e = ($urandom_range(9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 6));
        // aim the compare near the accumulator so the tolerance decides
        if (f == FUNC_EQUAL && $urandom_range(1)) begin
          op_re = acc_re[31:0] + ($signed($urandom_range(0, 6)) - 3);
          op_im = acc_im[31:0] + ($signed($urandom_range(0, 6)) - 3);
        end
        send_item(f, op_re, op_im, e, 1'b0, '{0, 0, 0, 0, 0}, idle_pct);
      end
    end
    start_i = 1'b0;

    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
